// ===== hw/rtl/windowed_shadow_buffer_delta_unit_defines.svh =====
// Assertion macros for the windowed shadow buffer delta unit.
`ifndef WINDOWED_SHADOW_BUFFER_DELTA_UNIT_DEFINES_SVH
`define WINDOWED_SHADOW_BUFFER_DELTA_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WSB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsb assertion failed");

// Next-cycle implication.
`define WSB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsb assertion failed");

`endif

// ===== hw/rtl/wsb_pkg.sv =====
// Shared constants, types and functions of the shadow buffer delta unit.
`timescale 1ns / 1ps
`default_nettype none
package wsb_pkg;

	localparam int WINDOW_W = 64;
	localparam int WINDOW_H = 32;
	localparam int DEPTH    = WINDOW_W * WINDOW_H;
	localparam int AW       = $clog2(DEPTH);
	localparam int COL_W    = $clog2(WINDOW_W);
	localparam int ROW_W    = $clog2(WINDOW_H);

	localparam logic signed [16:0] HALF_W  = 17'(WINDOW_W / 2);
	localparam logic signed [16:0] HALF_H  = 17'(WINDOW_H / 2);
	localparam logic signed [16:0] WIN_W_S = 17'(WINDOW_W);
	localparam logic signed [16:0] WIN_H_S = 17'(WINDOW_H);

	localparam logic signed [16:0] CAM_COL_RST = 17'sd5;
	localparam logic signed [16:0] CAM_ROW_RST = 17'sd10;
	localparam logic [7:0]         SPACE_CHAR  = 8'd32;

	localparam logic [14:0] WORLD_W_RST = 15'd128;
	localparam logic [14:0] WORLD_H_RST = 15'd64;

	localparam logic CMD_DRAW  = 1'b0;
	localparam logic CMD_FOCUS = 1'b1;

	typedef enum logic [1:0] {
		REG_WORLD_W = 2'd0,
		REG_WORLD_H = 2'd1,
		REG_OFF_X   = 2'd2,
		REG_OFF_Y   = 2'd3
	} wsb_reg_t;

	// Draw request toward the cell store, valid only for in-window draws.
	typedef struct packed {
		logic             vld;
		logic [AW-1:0]    addr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       ch;
	} wsb_draw_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [8:0] screen_col;
		logic [8:0] screen_row;
	} wsb_rec_t;

	typedef struct packed {
		logic busy;
		logic s1_vld;
	} wsb_stat_t;

	// Center on a point, clamp low to zero, then high to world minus window.
	function automatic logic signed [16:0] clamp_cam(
		input logic signed [15:0] centre,
		input logic signed [16:0] half,
		input logic signed [16:0] win,
		input logic [14:0]        world
	);
		logic signed [16:0] c;
		logic signed [16:0] hi;
		c  = 17'(centre) - half;
		hi = $signed({2'b00, world}) - win;
		if (c < 0) c = '0;
		if (c > hi) c = hi;
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wsb_front.sv =====
// Camera registers and world-to-window address mapping.
`timescale 1ns / 1ps
`default_nettype none
module wsb_front
	import wsb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               cmd,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [7:0]         char_code,
	input  logic [14:0]        world_w,
	input  logic [14:0]        world_h,
	output wsb_draw_t          req
);

	logic signed [16:0] cam_col_q, cam_row_q;
	logic signed [17:0] wc, wr;
	logic               in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_col_q <= CAM_COL_RST;
			cam_row_q <= CAM_ROW_RST;
		end else if (accept && cmd == CMD_FOCUS) begin
			cam_col_q <= clamp_cam(x_coord, HALF_W, WIN_W_S, world_w);
			cam_row_q <= clamp_cam(y_coord, HALF_H, WIN_H_S, world_h);
		end
	end

	assign wc = 18'(x_coord) - 18'(cam_col_q);
	assign wr = 18'(y_coord) - 18'(cam_row_q);

	assign in_win = !wc[17] && (wc[16:0] < 17'(WINDOW_W)) &&
	                !wr[17] && (wr[16:0] < 17'(WINDOW_H));

	always_comb begin
		req.vld  = accept && (cmd == CMD_DRAW) && in_win;
		req.col  = wc[COL_W-1:0];
		req.row  = wr[ROW_W-1:0];
		req.addr = AW'(req.row) * AW'(WINDOW_W) + AW'(req.col);
		req.ch   = char_code;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wsb_cell_store.sv =====
// Cell memory with clearing pass, read-compare-write stage and forwarding.
`timescale 1ns / 1ps
`default_nettype none
module wsb_cell_store
	import wsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  wsb_draw_t  req,
	input  logic [7:0] off_x,
	input  logic [7:0] off_y,
	output logic       rec_vld,
	output wsb_rec_t   rec,
	output wsb_stat_t  stat
);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rd_data_s1;

	logic             vld_s1;
	logic [AW-1:0]    addr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [7:0]       ch_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_data_s1;

	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic [7:0]       old_ch;
	logic             hit;

	// read-first port: a read of the entry written in the same cycle sees old data
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (req.vld) rd_data_s1 <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld) begin
			addr_s1     <= req.addr;
			col_s1      <= req.col;
			row_s1      <= req.row;
			ch_s1       <= req.ch;
			fwd_s1      <= hit && (addr_s1 == req.addr);
			fwd_data_s1 <= ch_s1;
		end
	end

	assign old_ch = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign hit    = vld_s1 && (old_ch != ch_s1);

	assign we    = clr_q || hit;
	assign waddr = clr_q ? clr_addr_q : addr_s1;
	assign wdata = clr_q ? SPACE_CHAR : ch_s1;

	assign rec_vld        = hit;
	assign rec.cell_char  = ch_s1;
	assign rec.screen_col = 9'(col_s1) + 9'(off_x);
	assign rec.screen_row = 9'(row_s1) + 9'(off_y);

	assign stat.busy   = clr_q;
	assign stat.s1_vld = vld_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/wsb_out_fifo.sv =====
// Small register queue of change records in front of the output port.
`timescale 1ns / 1ps
`default_nettype none
module wsb_out_fifo
	import wsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wsb_rec_t   push_rec,
	input  logic       pop,
	output logic       not_empty,
	output wsb_rec_t   head,
	output logic [2:0] count
);

	wsb_rec_t   slot_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

	assign not_empty = (count_q != 3'd0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/windowed_shadow_buffer_delta_unit.sv =====
// A changing draw request raises out_valid after passing the compare stage register and the output queue.
// Throughput: one request per cycle while in_ready is high; in_ready drops while the output queue backs up.
// Focus requests and draws that change nothing produce no output.
// Reset: asynchronous, active low; then a clearing pass fills every cell
// with a space, one entry per cycle, while in_ready stays low (config writes still taken).
`timescale 1ns / 1ps
`default_nettype none
module windowed_shadow_buffer_delta_unit
	import wsb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         cell_char,
	output logic [8:0]         screen_col,
	output logic [8:0]         screen_row,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data
);

	// configuration registers
	logic [14:0] world_w_q, world_h_q;
	logic [7:0]  off_x_q, off_y_q;

	logic        accept;
	wsb_draw_t   req;
	logic        rec_vld;
	wsb_rec_t    rec;
	wsb_stat_t   stat;
	wsb_rec_t    head;
	logic [2:0]  fifo_cnt;
	logic [3:0]  in_flight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q <= WORLD_W_RST;
			world_h_q <= WORLD_H_RST;
			off_x_q   <= '0;
			off_y_q   <= '0;
		end else if (cfg_we) begin
			case (wsb_reg_t'(cfg_index))
				REG_WORLD_W: world_w_q <= cfg_data;
				REG_WORLD_H: world_h_q <= cfg_data;
				REG_OFF_X:   off_x_q   <= cfg_data[7:0];
				REG_OFF_Y:   off_y_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Every request in the compare stage may still push a record; the queue has
	// four slots, so the queue plus that stage plus a new request never overflow.
	assign in_flight = 4'(fifo_cnt) + 4'(stat.s1_vld);
	assign in_ready  = !stat.busy && (in_flight <= 4'd2);
	assign accept    = in_valid && in_ready;

	wsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.char_code (char_code),
		.world_w   (world_w_q),
		.world_h   (world_h_q),
		.req       (req)
	);

	// memory read on accept, compare and write back in the following cycle
	wsb_cell_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.off_x   (off_x_q),
		.off_y   (off_y_q),
		.rec_vld (rec_vld),
		.rec     (rec),
		.stat    (stat)
	);

	wsb_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_vld),
		.push_rec  (rec),
		.pop       (out_valid && out_ready),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign cell_char  = head.cell_char;
	assign screen_col = head.screen_col;
	assign screen_row = head.screen_row;

endmodule
`default_nettype wire

// ===== hw/rtl/wsb_checker.sv =====
// Port-level checker for the shadow buffer delta unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_shadow_buffer_delta_unit_defines.svh"
module wsb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               cmd,
	input logic signed [15:0] x_coord,
	input logic signed [15:0] y_coord,
	input logic [7:0]         char_code,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         cell_char,
	input logic [8:0]         screen_col,
	input logic [8:0]         screen_row
);

	// a waiting input request holds
	`WSB_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable({cmd, x_coord, y_coord, char_code}))

	// a stalled record holds
	`WSB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({cell_char, screen_col, screen_row}))

	// a record appearing on an empty output comes from an accepted draw that passed the compare stage and the queue
	`WSB_ASSERT_IMP(a_out_src, out_valid && !$past(out_valid), $past(in_valid && in_ready, 2) && !$past(cmd, 2))

	// window index plus an 8-bit offset never exceeds 510
	`WSB_ASSERT_IMP(a_out_range, out_valid, screen_col <= 9'd510 && screen_row <= 9'd510)

endmodule

bind windowed_shadow_buffer_delta_unit wsb_checker u_wsb_checker (.*);
`default_nettype wire

// ===== sim/wsb_delta_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class: shadow cells, camera and config, plus the queue of expected change records.
package wsb_delta_check_pkg;
	import wsb_pkg::*;

	class shadow_cell_tracker;
		logic [7:0]         cells [DEPTH];
		logic signed [16:0] cam_col;
		logic signed [16:0] cam_row;
		logic [14:0]        world_w;
		logic [14:0]        world_h;
		logic [7:0]         off_x;
		logic [7:0]         off_y;
		wsb_rec_t           due_changes [$];
		int                 mismatches;

		function new();
			foreach (cells[i]) cells[i] = SPACE_CHAR;
			cam_col = CAM_COL_RST;
			cam_row = CAM_ROW_RST;
			world_w = WORLD_W_RST;
			world_h = WORLD_H_RST;
			off_x = '0;
			off_y = '0;
			mismatches = 0;
		endfunction

		function void write_reg(wsb_reg_t idx, logic [14:0] val);
			case (idx)
				REG_WORLD_W: world_w = val;
				REG_WORLD_H: world_h = val;
				REG_OFF_X:   off_x = val[7:0];
				REG_OFF_Y:   off_y = val[7:0];
				default: ;
			endcase
		endfunction

		// low clamp first, so a world narrower than the window ends up negative
		function logic signed [16:0] centered(int point, int span, int world);
			int c;
			int top;
			c = point - span / 2;
			top = world - span;
			if (c < 0) c = 0;
			if (c > top) c = top;
			return 17'(c);
		endfunction

		function logic [7:0] cell_at(int col, int row);
			return cells[row * WINDOW_W + col];
		endfunction

		function void note_request(logic c, logic signed [15:0] x, logic signed [15:0] y,
				logic [7:0] ch);
			int wc;
			int wr;
			int idx;
			wsb_rec_t rec;
			if (c == CMD_FOCUS) begin
				cam_col = centered(int'(x), WINDOW_W, int'(world_w));
				cam_row = centered(int'(y), WINDOW_H, int'(world_h));
				return;
			end
			wc = int'(x) - int'(cam_col);
			wr = int'(y) - int'(cam_row);
			if (wc < 0 || wc >= WINDOW_W || wr < 0 || wr >= WINDOW_H) return;
			idx = wr * WINDOW_W + wc;
			if (cells[idx] == ch) return;
			cells[idx] = ch;
			rec.cell_char = ch;
			rec.screen_col = 9'(wc + int'(off_x));
			rec.screen_row = 9'(wr + int'(off_y));
			due_changes = {due_changes, rec};
		endfunction

		task report(string msg);
			if (mismatches < 200) $display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task check_change(wsb_rec_t got);
			wsb_rec_t want;
			if (due_changes.size() == 0) begin
				report($sformatf("unexpected change record char %0d col %0d row %0d",
					got.cell_char, got.screen_col, got.screen_row));
				return;
			end
			want = due_changes.pop_front();
			if (got.cell_char !== want.cell_char)
				report($sformatf("cell_char %0d, expected %0d", got.cell_char, want.cell_char));
			if (got.screen_col !== want.screen_col)
				report($sformatf("screen_col %0d, expected %0d", got.screen_col, want.screen_col));
			if (got.screen_row !== want.screen_row)
				report($sformatf("screen_row %0d, expected %0d", got.screen_row, want.screen_row));
		endtask
	endclass

endpackage

// ===== sim/windowed_shadow_buffer_delta_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the shadow buffer delta unit: directed corners, then random phases, scoreboarded.
module windowed_shadow_buffer_delta_unit_tb;
	import wsb_pkg::*;
	import wsb_delta_check_pkg::*;

	// Cycles with no request taken on either side before giving up; covers the
	// clearing pass after reset and the long receiver hold-off.
	localparam int QUIET_LIMIT = 20000;
	// Requests per random phase that actually reach the cells or move the camera.
	localparam int PHASE_REQS  = 195;
	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = CMD_DRAW;
	logic signed [15:0] x_coord = '0;
	logic signed [15:0] y_coord = '0;
	logic [7:0]         char_code = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         cell_char;
	logic [8:0]         screen_col;
	logic [8:0]         screen_row;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [14:0]        cfg_data = '0;

	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	bit hold_rx       = 1'b0;
	int quiet_cycles  = 0;

	shadow_cell_tracker sb;

	windowed_shadow_buffer_delta_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cell_char (cell_char),
		.screen_col(screen_col),
		.screen_row(screen_row),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls per phase, or held off entirely during the pressure window.
	always @(negedge clk) begin
		out_ready <= !hold_rx && ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	// Monitor: results are checked before the request of the same edge is noted;
	// with the compare stage and output queue in between, no result can belong to that request.
	always @(posedge clk) begin
		wsb_rec_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.cell_char = cell_char;
				got.screen_col = screen_col;
				got.screen_row = screen_row;
				sb.check_change(got);
			end
			if (in_valid && in_ready) sb.note_request(cmd, x_coord, y_coord, char_code);
		end
	end

	// Watchdog on stretches with no request moving on either channel.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			quiet_cycles = quiet_cycles + 1;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** windowed_shadow_buffer_delta_unit: FAILED **");
			$finish;
		end
	end

	// Sender gap; always returns at a falling edge, after the previous request was noted.
	task automatic hold_gap();
		@(negedge clk);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
		end
	endtask

	// Present one request and hold it until taken.
	task automatic drive_request(logic c, logic signed [15:0] x, logic signed [15:0] y,
			logic [7:0] ch);
		in_valid <= 1'b1;
		cmd <= c;
		x_coord <= x;
		y_coord <= y;
		char_code <= ch;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic directed(logic c, logic signed [15:0] x, logic signed [15:0] y,
			logic [7:0] ch);
		hold_gap();
		drive_request(c, x, y, ch);
	endtask

	// Mostly draws aimed inside the current window, some just past a border,
	// camera moves over the world, and a share of fully random requests.
	task automatic random_request(output bit counts);
		int cc;
		int cr;
		int col;
		int row;
		int r;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0] ch;
		logic c;
		hold_gap();
		cc = int'(sb.cam_col);
		cr = int'(sb.cam_row);
		r = $urandom_range(0, 99);
		c = CMD_DRAW;
		ch = 8'($urandom);
		counts = 1'b0;
		if (r < 62) begin
			col = $urandom_range(0, WINDOW_W - 1);
			row = $urandom_range(0, WINDOW_H - 1);
			// rewrite the stored char now and then: must stay silent
			if ($urandom_range(0, 9) == 0) ch = sb.cell_at(col, row);
			x = 16'(cc + col);
			y = 16'(cr + row);
			counts = 1'b1;
		end else if (r < 72) begin
			if ($urandom_range(0, 1)) begin
				col = $urandom_range(0, 1) ? -1 : WINDOW_W;
				row = $urandom_range(0, WINDOW_H - 1);
			end else begin
				col = $urandom_range(0, WINDOW_W - 1);
				row = $urandom_range(0, 1) ? -1 : WINDOW_H;
			end
			x = 16'(cc + col);
			y = 16'(cr + row);
		end else if (r < 86) begin
			c = CMD_FOCUS;
			x = 16'(int'($urandom_range(0, sb.world_w + 40)) - 20);
			y = 16'(int'($urandom_range(0, sb.world_h + 40)) - 20);
			counts = 1'b1;
		end else begin
			c = 1'($urandom);
			x = 16'($urandom);
			y = 16'($urandom);
			counts = (c == CMD_FOCUS);
		end
		drive_request(c, x, y, ch);
	endtask

	task automatic stream_phase();
		int done;
		bit counts;
		done = 0;
		while (done < PHASE_REQS) begin
			random_request(counts);
			done += counts;
		end
	endtask

	task automatic set_reg(wsb_reg_t idx, logic [14:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [14:0] ww, logic [14:0] wh, logic [7:0] ox, logic [7:0] oy);
		set_reg(REG_WORLD_W, ww);
		set_reg(REG_WORLD_H, wh);
		set_reg(REG_OFF_X, 15'(ox));
		set_reg(REG_OFF_Y, 15'(oy));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every expected record, then a few cycles more: silent draws and
	// focus requests may still be in the pipe when the last record leaves.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_changes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [14:0] ww;
		logic [14:0] wh;
		logic [7:0]  ox;
		logic [7:0]  oy;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset camera (5,10) and reset world, no clamp applied; waits out the clearing pass.
		directed(CMD_DRAW, 16'sd5, 16'sd10, 8'd65);
		directed(CMD_DRAW, 16'sd68, 16'sd41, 8'hFF);
		directed(CMD_DRAW, 16'sd5, 16'sd10, 8'd65);     // same char, silent
		directed(CMD_DRAW, 16'sd6, 16'sd10, SPACE_CHAR); // matches reset fill
		directed(CMD_DRAW, 16'sd4, 16'sd10, 8'd1);      // left of window
		directed(CMD_DRAW, 16'sd69, 16'sd10, 8'd1);     // right of window
		directed(CMD_DRAW, 16'sd5, 16'sd9, 8'd1);       // above
		directed(CMD_DRAW, 16'sd5, 16'sd42, 8'd1);      // below
		directed(CMD_DRAW, -16'sd32768, 16'sd32767, 8'd0);
		directed(CMD_FOCUS, 16'sd32767, -16'sd32768, 8'hFF);
		directed(CMD_DRAW, 16'sd64, 16'sd0, 8'd0);
		directed(CMD_DRAW, 16'sd127, 16'sd31, 8'h80);
		drain();

		// World smaller than the window: camera goes negative; offsets at maximum.
		set_config(15'd10, 15'd5, 8'd255, 8'd255);
		directed(CMD_FOCUS, 16'sd0, 16'sd0, 8'd0);
		directed(CMD_DRAW, -16'sd54, -16'sd27, 8'h55);
		directed(CMD_DRAW, 16'sd9, 16'sd4, 8'hAA);
		directed(CMD_DRAW, 16'sd10, 16'sd4, 8'd1);
		directed(CMD_DRAW, -16'sd55, -16'sd27, 8'd1);
		directed(CMD_DRAW, -16'sd54, -16'sd28, 8'd1);
		directed(CMD_FOCUS, -16'sd32768, -16'sd32768, 8'd0);
		directed(CMD_DRAW, -16'sd54, -16'sd27, 8'hAA);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					ww = 15'd128; wh = 15'd64; ox = 8'd0; oy = 8'd0;
				end
				1: begin
					ww = 15'd32767; wh = 15'd32767; ox = 8'd255; oy = 8'd0;
				end
				2: begin
					ww = 15'd0; wh = 15'd0; ox = 8'd0; oy = 8'd255;
				end
				3: begin
					ww = 15'd32767; wh = 15'd0; ox = 8'd255; oy = 8'd255;
				end
				default: begin
					ww = 15'($urandom_range(0, 1) ? $urandom_range(0, 300)
						: $urandom_range(0, 32767));
					wh = 15'($urandom_range(0, 1) ? $urandom_range(0, 300)
						: $urandom_range(0, 32767));
					ox = 8'($urandom);
					oy = 8'($urandom);
				end
			endcase
			// idle mix: none, sender, receiver, both
			case (p % 4)
				0: begin
					snd_idle_pct = 0; rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct = 66; rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct = 0; rcv_stall_pct = 66;
				end
				default: begin
					snd_idle_pct = 36; rcv_stall_pct = 36;
				end
			endcase
			set_config(ww, wh, ox, oy);
			if (p == 0) begin
				// Receiver held off while the sender keeps offering: the pipe fills and
				// in_ready must drop without losing or duplicating a record.
				fork
					begin
						repeat (40) @(posedge clk);
						hold_rx = 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_rx = 1'b0;
					end
					stream_phase();
				join
			end else begin
				stream_phase();
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("** windowed_shadow_buffer_delta_unit: PASSED **");
		else
			$display("** windowed_shadow_buffer_delta_unit: FAILED **");
		$finish;
	end

endmodule
